### rtl/core/rfp_pkg.sv
// rfp_pkg: shared types, phase codes, status codes and register indexes
// for the response frame parser. No dependencies.

package rfp_pkg;

  localparam logic [7:0] START_MARK = 8'hE0;
  localparam logic [7:0] REPLY_BIT  = 8'h40;

  // parser phases
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_CNT_OK  = 3'd2;
  localparam logic [2:0] PH_CNT_BAD = 3'd3;
  localparam logic [2:0] PH_LEN     = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;
  localparam logic [2:0] PH_END     = 3'd6;

  // frame status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_COMMAND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_LIMIT    = 2'd1;

  typedef struct packed {
    logic [7:0] expected_command;
    logic [8:0] capture_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] params_left;
    logic [7:0] bytes_left;
    logic       on_first_param;
    logic [7:0] byte_position;
    logic [8:0] capture_total;
  } state_t;

  typedef struct packed {
    logic       capture_valid;
    logic [7:0] capture_index;
    logic [7:0] capture_data;
    logic       frame_end;
    logic [1:0] frame_status;
    logic [8:0] captured_count;
  } result_t;

  function automatic state_t hunt_state();
    state_t s;
    s.phase          = PH_HUNT;
    s.params_left    = 8'd0;
    s.bytes_left     = 8'd0;
    s.on_first_param = 1'b1;
    s.byte_position  = 8'd0;
    s.capture_total  = 9'd0;
    return s;
  endfunction

endpackage

### rtl/core/response_frame_parser.sv
// response_frame_parser: top level of the reply frame parser.
// Depends on rfp_pkg, rfp_step and rfp_out_buf.
//
// Input channel: rx_byte and restart, transferred on in_valid && in_ready.
// Output channel: one result per input byte (capture_valid, capture_index,
// capture_data, frame_end, frame_status, captured_count), transferred on
// out_valid && out_ready.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge
// (0 expected_command, 1 capture_limit); other indexes are ignored. Write
// only while no result is outstanding.
// Timing: a byte's result is on the output in the cycle after its transfer
// when the output register is free; behind a stalled result it waits in
// the skid slot. Throughput: one byte per cycle while in_ready is high, set
// by the combinational parse between the frame state and output registers.
// Stall: a two-entry output buffer holds results; in_ready drops only once
// both entries are full, and returns the cycle after the receiver takes one.
// Reset (rst, synchronous): parser hunts for the start marker, output buffer
// empties, expected_command = 0, capture_limit = 1.

module response_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            capture_valid,
  output logic [7:0]                      capture_index,
  output logic [7:0]                      capture_data,
  output logic                            frame_end,
  output logic [1:0]                      frame_status,
  output logic [8:0]                      captured_count,
  input  logic                            cfg_we,
  input  logic [rfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [8:0]                      cfg_data
);

  rfp_pkg::cfg_t    cfg;
  rfp_pkg::state_t  state;
  rfp_pkg::state_t  state_next;
  rfp_pkg::result_t step_res;
  rfp_pkg::result_t out_res;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_command <= 8'd0;
      cfg.capture_limit    <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        rfp_pkg::REG_EXPECTED_COMMAND: cfg.expected_command <= cfg_data[7:0];
        rfp_pkg::REG_CAPTURE_LIMIT:    cfg.capture_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rfp_pkg::hunt_state();
    else if (accept) state <= state_next;
  end

  rfp_step u_step (
    .cfg     (cfg),
    .cur     (state),
    .rx_byte (rx_byte),
    .restart (restart),
    .nxt     (state_next),
    .res     (step_res)
  );

  rfp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (step_res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign capture_valid  = out_res.capture_valid;
  assign capture_index  = out_res.capture_index;
  assign capture_data   = out_res.capture_data;
  assign frame_end      = out_res.frame_end;
  assign frame_status   = out_res.frame_status;
  assign captured_count = out_res.captured_count;

endmodule

### rtl/core/rfp_step.sv
// rfp_step: combinational parse of one byte against the current frame state.
// Gives the next state and the result for that byte. Uses rfp_pkg.

module rfp_step (
  input  rfp_pkg::cfg_t    cfg,
  input  rfp_pkg::state_t  cur,
  input  logic [7:0]       rx_byte,
  input  logic             restart,
  output rfp_pkg::state_t  nxt,
  output rfp_pkg::result_t res
);

  rfp_pkg::state_t s;
  logic [7:0]      reply_code;
  logic [7:0]      params_dec;
  logic [7:0]      bytes_dec;
  logic            param_end;

  assign reply_code = cfg.expected_command | rfp_pkg::REPLY_BIT;

  always_comb begin
    s = restart ? rfp_pkg::hunt_state() : cur;
    params_dec = s.params_left - 8'd1;
    bytes_dec  = s.bytes_left - 8'd1;
    nxt       = s;
    res       = '0;
    param_end = 1'b0;

    case (s.phase)
      rfp_pkg::PH_HUNT: begin
        if (rx_byte == rfp_pkg::START_MARK) nxt.phase = rfp_pkg::PH_CMD;
      end
      rfp_pkg::PH_CMD: begin
        nxt.phase = (rx_byte == reply_code) ? rfp_pkg::PH_CNT_OK : rfp_pkg::PH_CNT_BAD;
      end
      rfp_pkg::PH_CNT_OK, rfp_pkg::PH_CNT_BAD: begin
        // a bad command still consumes the count byte and reports on it; a zero count is also bad
        if (s.phase == rfp_pkg::PH_CNT_BAD || rx_byte == 8'd0) begin
          res.frame_end    = 1'b1;
          res.frame_status = rfp_pkg::ST_BAD;
          nxt              = rfp_pkg::hunt_state();
        end else begin
          nxt.params_left    = rx_byte;
          nxt.on_first_param = 1'b1;
          nxt.byte_position  = 8'd0;
          nxt.capture_total  = 9'd0;
          nxt.phase          = rfp_pkg::PH_LEN;
        end
      end
      rfp_pkg::PH_LEN: begin
        nxt.bytes_left = rx_byte;
        if (rx_byte == 8'd0) param_end = 1'b1;
        else                 nxt.phase = rfp_pkg::PH_DATA;
      end
      rfp_pkg::PH_DATA: begin
        if (s.on_first_param && ({1'b0, s.byte_position} < cfg.capture_limit)) begin
          res.capture_valid = 1'b1;
          res.capture_index = s.byte_position;
          res.capture_data  = rx_byte;
          nxt.capture_total = s.capture_total + 9'd1;
        end
        if (s.on_first_param) nxt.byte_position = s.byte_position + 8'd1;
        nxt.bytes_left = bytes_dec;
        if (bytes_dec == 8'd0) param_end = 1'b1;
      end
      rfp_pkg::PH_END: begin
        res.frame_end    = 1'b1;
        res.frame_status = rfp_pkg::ST_DONE;
      end
      default: begin
        nxt = rfp_pkg::hunt_state();
      end
    endcase

    if (param_end) begin
      nxt.params_left    = params_dec;
      nxt.on_first_param = 1'b0;
      nxt.phase          = (params_dec == 8'd0) ? rfp_pkg::PH_END : rfp_pkg::PH_LEN;
    end

    res.captured_count = nxt.capture_total;

    // total is reported on the end byte, then cleared
    if (s.phase == rfp_pkg::PH_END) nxt = rfp_pkg::hunt_state();
  end

endmodule

### rtl/core/rfp_out_buf.sv
// rfp_out_buf: two-entry output register with skid slot, so a new byte is
// taken while a result waits. Uses rfp_pkg.

module rfp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rfp_pkg::result_t load_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output rfp_pkg::result_t out_data
);

  logic             skid_valid;
  rfp_pkg::result_t skid_data;
  logic             drain;

  assign space = !skid_valid;
  assign drain = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (!out_valid || drain) begin
        out_data  <= load_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= load_data;
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/rfp_checker.sv
// rfp_checker: port-level assertions on the response frame parser, bound to
// the top level. Uses rfp_pkg status codes.

module rfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       capture_valid,
  input logic [7:0] capture_index,
  input logic [7:0] capture_data,
  input logic       frame_end,
  input logic [1:0] frame_status,
  input logic [8:0] captured_count
);

  // a frame end always carries a final status, and only an end does
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_end == (frame_status != rfp_pkg::ST_BUSY)))
    else $error("frame_end and frame_status disagree");

  // a captured byte is never the last of a frame, and the count covers it
  a_capture_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && capture_valid) |->
      (!frame_end && captured_count != 9'd0 && {1'b0, capture_index} < captured_count))
    else $error("capture outside a frame body or count too small");

  // a bad frame reports nothing captured
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == rfp_pkg::ST_BAD) |->
      (captured_count == 9'd0 && !capture_valid))
    else $error("bad frame with captured bytes");

  // a stalled result holds its data, count and end flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(capture_data) && $stable(captured_count) && $stable(frame_end)))
    else $error("result changed while stalled");

endmodule

bind response_frame_parser rfp_checker u_rfp_checker (.*);
